FILE: rtl/core/geq_pkg.sv
// geq_pkg: shared types, opcodes and constants for the gated event queue
// no dependencies
`timescale 1ns / 1ps
package geq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = 69;
  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef enum logic [2:0] {
    OP_ADD_TAIL  = 3'd0,
    OP_ADD_HEAD  = 3'd1,
    OP_IN_ERR    = 3'd2,
    OP_SET_EN    = 3'd3,
    OP_FIRE      = 3'd4,
    OP_ABORT     = 3'd5,
    OP_CLR_IN    = 3'd6,
    OP_CLR_OUT   = 3'd7
  } opcode_t;

  localparam logic [1:0] KIND_ORDINARY = 2'd0;
  localparam logic [1:0] KIND_IN_ERR   = 2'd1;
  localparam logic [1:0] KIND_IN_DATA  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       is_output;
    logic       needs_data;
    logic       is_data;
  } attrs_t;

  typedef struct packed {
    logic [31:0] word_a;
    logic [31:0] word_b;
    attrs_t      attrs;
  } entry_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic        is_data;
    logic        needs_data;
    logic        is_output;
    logic        enable_any;
    logic        enable_data;
  } in_req_t;

  typedef struct packed {
    logic        fire_request;
    logic        fired;
    logic [1:0]  out_kind;
    logic [31:0] out_word_a;
    logic [31:0] out_word_b;
    logic        out_is_data;
    logic        out_needs_data;
    logic        out_is_output;
    logic [4:0]  queue_count;
    logic [4:0]  data_count;
    logic        dropped;
  } out_res_t;
endpackage

FILE: rtl/core/geq_ram.sv
// geq_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
module geq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/gated_event_queue.sv
// gated_event_queue: top level, sequencer around one entry memory
// depends on geq_pkg and geq_ram
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; its single result
// appears on out_ for one cycle with out_valid high, and the receiver cannot
// stall it. Adds, set enables, fire and abort pass through S_EXEC, S_DONE and
// S_HEAD. An input error always adds S_PUSH2: the tail entry is written in a
// state of its own, whether or not the head bracket is written. The clears walk
// every queued entry through the single read port of the entry memory,
// compacting in place: each entry is read in S_WALK, then copied down in
// S_MOVE if kept. The memory needs no clearing pass: only entries inside the
// queue are ever used.
module gated_event_queue
  import geq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,  // apply push, enables or abort, launch head read
    S_HEAD  = 7'b0000100,  // head data back from memory, evaluate request
    S_WALK  = 7'b0001000,  // clear: issue read of next entry
    S_MOVE  = 7'b0010000,  // clear: entry back, copy down if kept
    S_DONE  = 7'b0100000,
    S_PUSH2 = 7'b1000000   // second push of an input error
  } state_t;

  state_t state_r, state_nxt;
  in_req_t req_r, req_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [4:0] dcount_r, dcount_nxt;
  logic all_en_r, all_en_nxt, data_en_r, data_en_nxt;
  logic drop_r, drop_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  out_res_t res_r, res_nxt;
  logic vld_r, vld_nxt;

  // memory port
  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t wdata, rdata;

  geq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic full;
  assign full = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign busy = (state_r != S_IDLE);
  assign out_valid = vld_r;
  assign out_res = res_r;

  function automatic logic [IDX_W-1:0] slot(logic [IDX_W-1:0] h, logic [CNT_W-1:0] off);
    slot = h + off[IDX_W-1:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    head_nxt = head_r;
    count_nxt = count_r;
    dcount_nxt = dcount_r;
    all_en_nxt = all_en_r;
    data_en_nxt = data_en_r;
    drop_nxt = drop_r;
    rd_nxt = rd_r;
    wr_nxt = wr_r;
    res_nxt = res_r;
    vld_nxt = 1'b0;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = head_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          drop_nxt = 1'b0;
          rd_nxt = '0;
          wr_nxt = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // raddr = head_r here: for fire, head data arrives next cycle
        unique case (opcode_t'(req_r.opcode))
          OP_ADD_TAIL, OP_ADD_HEAD: begin
            wdata.word_a = req_r.word_a;
            wdata.word_b = req_r.word_b;
            wdata.attrs = '{kind: KIND_ORDINARY, is_output: req_r.is_output,
                            needs_data: req_r.needs_data, is_data: req_r.is_data};
            if (full) begin
              drop_nxt = 1'b1;
            end else begin
              we = 1'b1;
              if (req_r.opcode == OP_ADD_HEAD) begin
                head_nxt = head_r - 1'b1;
                waddr = head_nxt;
              end else begin
                waddr = slot(head_r, count_r);
              end
              count_nxt = count_r + 1'b1;
              if (req_r.is_data && dcount_r < COUNT_MAX) dcount_nxt = dcount_r + 1'b1;
            end
            state_nxt = S_DONE;
          end
          OP_IN_ERR: begin
            wdata.word_a = req_r.word_a;
            wdata.word_b = req_r.word_b;
            wdata.attrs = '{kind: KIND_IN_DATA, is_output: 1'b0,
                            needs_data: 1'b1, is_data: 1'b0};
            if (dcount_r != '0) begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                we = 1'b1;
                head_nxt = head_r - 1'b1;
                waddr = head_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            state_nxt = S_PUSH2;
          end
          OP_SET_EN: begin
            all_en_nxt = req_r.enable_any;
            data_en_nxt = req_r.enable_data;
            state_nxt = S_DONE;
          end
          OP_FIRE: state_nxt = S_DONE;
          OP_ABORT: begin
            count_nxt = '0;
            dcount_nxt = '0;
            state_nxt = S_DONE;
          end
          OP_CLR_IN, OP_CLR_OUT: begin
            state_nxt = S_WALK;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_PUSH2: begin
        wdata.word_a = req_r.word_a;
        wdata.word_b = req_r.word_b;
        wdata.attrs = '{kind: KIND_IN_ERR, is_output: 1'b0,
                        needs_data: 1'b1, is_data: 1'b0};
        if (full) begin
          drop_nxt = 1'b1;
        end else begin
          we = 1'b1;
          waddr = slot(head_r, count_r);
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // head read for the post-op queue (also serves fire's pre-op head)
        raddr = head_r;
        state_nxt = S_HEAD;
      end
      S_WALK: begin
        if (rd_r == count_r) begin
          count_nxt = wr_r;
          if (req_r.opcode == OP_CLR_IN) dcount_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          raddr = slot(head_r, rd_r);
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        if (((req_r.opcode == OP_CLR_IN) ? rdata.attrs.needs_data
                                         : rdata.attrs.is_output) == 1'b0) begin
          we = 1'b1;
          waddr = slot(head_r, wr_r);
          wdata = rdata;
          wr_nxt = wr_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
        state_nxt = S_WALK;
      end
      S_HEAD: begin
        // rdata is the head entry; count_r is the queue after the op (before the pop, for fire)
        res_nxt = '0;
        res_nxt.dropped = drop_r;
        unique case (opcode_t'(req_r.opcode))
          OP_ADD_TAIL, OP_ADD_HEAD, OP_IN_ERR: begin
            res_nxt.fire_request = all_en_r && (count_r != '0) &&
              !(rdata.attrs.needs_data && !data_en_r) &&
              (!rdata.attrs.is_data || dcount_r == 5'd1);
          end
          OP_SET_EN: begin
            res_nxt.fire_request = all_en_r && (count_r != '0) &&
              !(rdata.attrs.needs_data && !data_en_r);
          end
          OP_FIRE: begin
            if (all_en_r && (count_r != '0) &&
                !(rdata.attrs.needs_data && !data_en_r)) begin
              res_nxt.fired = 1'b1;
              res_nxt.out_kind = rdata.attrs.kind;
              res_nxt.out_word_a = rdata.word_a;
              res_nxt.out_word_b = rdata.word_b;
              res_nxt.out_is_data = rdata.attrs.is_data;
              res_nxt.out_needs_data = rdata.attrs.needs_data;
              res_nxt.out_is_output = rdata.attrs.is_output;
              head_nxt = head_r + 1'b1;
              count_nxt = count_r - 1'b1;
              if (rdata.attrs.is_data) begin
                if (dcount_r != '0) dcount_nxt = dcount_r - 1'b1;
                data_en_nxt = 1'b0;
              end
            end
          end
          default: ;
        endcase
        res_nxt.queue_count = 5'(count_nxt);
        res_nxt.data_count = dcount_nxt;
        vld_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      count_r <= '0;
      dcount_r <= '0;
      all_en_r <= 1'b0;
      data_en_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      count_r <= count_nxt;
      dcount_r <= dcount_nxt;
      all_en_r <= all_en_nxt;
      data_en_r <= data_en_nxt;
      vld_r <= vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    drop_r <= drop_nxt;
    rd_r <= rd_nxt;
    wr_r <= wr_nxt;
    res_r <= res_nxt;
  end
endmodule
